FILE: rtl/rsvpe_pkg.sv
// Shared constants, types and GF(2^16) arithmetic for the Vandermonde parity encoder.
package rsvpe_pkg;

   localparam int MAX_PARITY = 8;
   localparam int MAX_DATA   = 16;
   localparam int SYM_W      = 16;
   localparam int ROW_W      = 3;
   localparam int CFG_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int LANE_W     = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
   localparam int CNT_W      = $clog2(MAX_DATA);
   localparam int CALC_W     = 8;

   localparam logic [SYM_W-1:0] FIELD_LOW_POLY = 16'h100B;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_COUNT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_COUNT = CSR_IDX_W'(1);

   typedef struct packed {
      logic              accum;
      logic              clear;
      logic              load_out;
      logic [LANE_W-1:0] row;
      logic              last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // multiply by x, reduce by x^16+x^12+x^3+x+1
   function automatic logic [SYM_W-1:0] gf_mul_x(input logic [SYM_W-1:0] v);
      logic [SYM_W-1:0] shifted;
      shifted = {v[SYM_W-2:0], 1'b0};
      return v[SYM_W-1] ? (shifted ^ FIELD_LOW_POLY) : shifted;
   endfunction

   function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b);
      logic [SYM_W-1:0] x;
      logic [SYM_W-1:0] acc;
      x   = a;
      acc = '0;
      for (int bit_idx = 0; bit_idx < SYM_W; bit_idx++) begin
         if (b[bit_idx]) begin
            acc = acc ^ x;
         end
         x = gf_mul_x(x);
      end
      return acc;
   endfunction

   // evaluation point of a parity row: 2^row
   function automatic logic [SYM_W-1:0] row_point(input int row);
      logic [SYM_W-1:0] p;
      p = SYM_W'(1);
      for (int k = 0; k < MAX_PARITY; k++) begin
         if (k < row) begin
            p = gf_mul_x(p);
         end
      end
      return p;
   endfunction

endpackage

FILE: rtl/rs_vandermonde_parity_encoder_gf16.sv
// Top level of the GF(2^16) Vandermonde erasure-code parity encoder.
// Feed the K data symbols of one stripe position on req_* in chunk order; each accepted
// beat updates all MAX_PARITY row accumulators in the same cycle (one GF multiply-accumulate
// lane per row), so data symbols go in at one per cycle. On the K-th symbol the input stalls
// while the P = N-K parity symbols (clipped to 1..MAX_PARITY) leave on rsp_* in row order,
// one per cycle through the output register unless rsp_stall holds it, the last one flagged by
// rsp_last_parity. Write data_count (index 0) and total_count (index 1) on csr_* only while the
// block is idle; other indexes are ignored.
module rs_vandermonde_parity_encoder_gf16
   import rsvpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SYM_W-1:0]     req_data_symbol,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SYM_W-1:0]     rsp_parity_symbol,
   output logic [ROW_W-1:0]     rsp_parity_row,
   output logic                 rsp_last_parity,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rsvpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

   rsvpe_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .data_symbol       (req_data_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_parity_symbol (rsp_parity_symbol),
      .rsp_parity_row    (rsp_parity_row),
      .rsp_last_parity   (rsp_last_parity)
   );

endmodule

FILE: rtl/rsvpe_dp.sv
// Datapath: one GF multiply-accumulate lane per parity row and the result register.
module rsvpe_dp
   import rsvpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [SYM_W-1:0]     data_symbol,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SYM_W-1:0]     rsp_parity_symbol,
   output logic [ROW_W-1:0]     rsp_parity_row,
   output logic                 rsp_last_parity
);

   logic [SYM_W-1:0] acc_ff  [MAX_PARITY];
   logic [SYM_W-1:0] acc_in  [MAX_PARITY];
   logic [SYM_W-1:0] coef_ff [MAX_PARITY];
   logic [SYM_W-1:0] coef_in [MAX_PARITY];

   logic             rsp_valid_ff;
   logic [SYM_W-1:0] rsp_symbol_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic             rsp_last_ff;

   for (genvar lane = 0; lane < MAX_PARITY; lane++) begin : g_lane
      localparam logic [SYM_W-1:0] POINT = row_point(lane);

      assign acc_in[lane]  = acc_ff[lane] ^ gf_mul(data_symbol, coef_ff[lane]);
      assign coef_in[lane] = gf_mul(coef_ff[lane], POINT);

      always_ff @(posedge clock) begin
         if (reset || cmd.clear) begin
            acc_ff[lane]  <= '0;
            coef_ff[lane] <= SYM_W'(1);
         end else if (cmd.accum) begin
            acc_ff[lane]  <= acc_in[lane];
            coef_ff[lane] <= coef_in[lane];
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_symbol_ff <= acc_ff[cmd.row];
         rsp_row_ff    <= ROW_W'(cmd.row);
         rsp_last_ff   <= cmd.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_parity_symbol = rsp_symbol_ff;
   assign rsp_parity_row    = rsp_row_ff;
   assign rsp_last_parity   = rsp_last_ff;

endmodule

FILE: rtl/rsvpe_ctrl.sv
// Controller: configuration registers, symbol count and the parity emit sequencer.
module rsvpe_ctrl
   import rsvpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output dp_cmd_type           cmd,
   input  dp_status_type        status
);

   typedef enum logic {
      ST_TAKE,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [LANE_W-1:0] row_ff;
   logic [LANE_W-1:0] last_row_ff;
   logic [CFG_W-1:0]  data_count_ff;
   logic [CFG_W-1:0]  total_count_ff;

   logic [CALC_W-1:0] eff_k;
   logic [CALC_W-1:0] eff_p;
   logic [CALC_W-1:0] total_ext;
   logic [CALC_W-1:0] taken;
   logic              accept;
   logic              stripe_end;
   logic              emit_last;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_count_ff  <= CFG_W'(3);
         total_count_ff <= CFG_W'(5);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DATA_COUNT:  data_count_ff  <= csr_wdata;
            CSR_TOTAL_COUNT: total_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clip K to 1..MAX_DATA and N-K to 1..MAX_PARITY
   always_comb begin
      total_ext = CALC_W'(total_count_ff);
      if (data_count_ff == '0) begin
         eff_k = CALC_W'(1);
      end else if (CALC_W'(data_count_ff) > CALC_W'(MAX_DATA)) begin
         eff_k = CALC_W'(MAX_DATA);
      end else begin
         eff_k = CALC_W'(data_count_ff);
      end
      if (total_ext <= eff_k) begin
         eff_p = CALC_W'(1);
      end else if (total_ext - eff_k > CALC_W'(MAX_PARITY)) begin
         eff_p = CALC_W'(MAX_PARITY);
      end else begin
         eff_p = total_ext - eff_k;
      end
   end

   assign req_stall  = (state_ff != ST_TAKE);
   assign accept     = req_valid && !req_stall;
   assign taken      = CALC_W'(count_ff) + CALC_W'(1);
   assign stripe_end = (taken >= eff_k);
   assign emit_last  = (row_ff == last_row_ff);

   always_comb begin
      cmd.accum    = accept;
      cmd.load_out = (state_ff == ST_EMIT) && status.out_free;
      cmd.clear    = cmd.load_out && emit_last;
      cmd.row      = row_ff;
      cmd.last     = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_TAKE;
         count_ff    <= '0;
         row_ff      <= '0;
         last_row_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_TAKE: begin
               if (accept) begin
                  if (stripe_end) begin
                     count_ff    <= '0;
                     row_ff      <= '0;
                     last_row_ff <= LANE_W'(eff_p - CALC_W'(1));
                     state_ff    <= ST_EMIT;
                  end else begin
                     count_ff <= CNT_W'(taken);
                  end
               end
            end
            ST_EMIT: begin
               // advance one row per free output slot
               if (status.out_free) begin
                  if (emit_last) begin
                     state_ff <= ST_TAKE;
                  end else begin
                     row_ff <= row_ff + LANE_W'(1);
                  end
               end
            end
            default: state_ff <= ST_TAKE;
         endcase
      end
   end

   a_clear_ends_emit : assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (state_ff == ST_TAKE) && !cmd.load_out)
      else $error("emit sequence did not end after the final parity row");

   a_row_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (row_ff <= last_row_ff))
      else $error("parity row index passed the last row");

   a_no_accum_while_emit : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !cmd.accum)
      else $error("accumulators updated while parity rows are being read out");

   a_stripe_end_enters_emit : assert property (@(posedge clock) disable iff (reset)
      accept && stripe_end |=> (state_ff == ST_EMIT) && (row_ff == '0))
      else $error("stripe end did not start the parity readout");

endmodule

FILE: verif/rs_vandermonde_parity_encoder_gf16_test.sv
// Self-checking testbench for the GF(2^16) Vandermonde parity encoder.
module rs_vandermonde_parity_encoder_gf16_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rsvpe_pkg::*;

   localparam logic [SYM_W-1:0] REDUCE_TAIL = 16'h100B;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_SYMBOLS = 60;

   // indexes that map to no register
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_B = CSR_IDX_W'(3);

   typedef struct {
      logic [SYM_W-1:0] symbol;
      logic [ROW_W-1:0] row;
      logic             last;
   } parity_beat_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [SYM_W-1:0]     req_data_symbol;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [SYM_W-1:0]     rsp_parity_symbol;
   logic [ROW_W-1:0]     rsp_parity_row;
   logic                 rsp_last_parity;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   // predictor state
   logic [SYM_W-1:0] row_sum    [MAX_PARITY];
   logic [SYM_W-1:0] row_weight [MAX_PARITY];
   logic [SYM_W-1:0] row_base   [MAX_PARITY];
   logic [CFG_W-1:0] k_setting;
   logic [CFG_W-1:0] total_chunks;
   int               symbols_taken;

   parity_beat_type pending_parity[$];

   int failures;
   int symbols_sent;
   int beats_checked;
   int csr_writes;
   int send_idle_pct;
   int recv_stall_pct;

   rs_vandermonde_parity_encoder_gf16 i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_symbol   (req_data_symbol),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_parity_symbol (rsp_parity_symbol),
      .rsp_parity_row    (rsp_parity_row),
      .rsp_last_parity   (rsp_last_parity),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [SYM_W-1:0] gf_double(input logic [SYM_W-1:0] v);
      return {v[SYM_W-2:0], 1'b0} ^ (v[SYM_W-1] ? REDUCE_TAIL : '0);
   endfunction

   // Horner form: walk the bits of a from the top
   function automatic logic [SYM_W-1:0] gf_times(input logic [SYM_W-1:0] a,
                                                 input logic [SYM_W-1:0] b);
      logic [SYM_W-1:0] prod;
      prod = '0;
      for (int i = SYM_W - 1; i >= 0; i--) begin
         prod = gf_double(prod);
         if (a[i]) begin
            prod = prod ^ b;
         end
      end
      return prod;
   endfunction

   function automatic int stripe_length();
      if (k_setting < 1) begin
         return 1;
      end
      if (k_setting > MAX_DATA) begin
         return MAX_DATA;
      end
      return int'(k_setting);
   endfunction

   function automatic int parity_rows();
      int k;
      k = stripe_length();
      if (int'(total_chunks) <= k) begin
         return 1;
      end
      if (int'(total_chunks) - k > MAX_PARITY) begin
         return MAX_PARITY;
      end
      return int'(total_chunks) - k;
   endfunction

   task automatic clear_encoder_model();
      logic [SYM_W-1:0] point;
      point         = SYM_W'(1);
      k_setting     = CFG_W'(3);
      total_chunks  = CFG_W'(5);
      symbols_taken = 0;
      for (int i = 0; i < MAX_PARITY; i++) begin
         row_sum[i]    = '0;
         row_weight[i] = SYM_W'(1);
         row_base[i]   = point;
         point         = gf_double(point);
      end
   endtask

   // fold one data symbol into every row; close the stripe on the K-th
   task automatic absorb_symbol(input logic [SYM_W-1:0] sym);
      parity_beat_type beat;
      int              rows;
      for (int i = 0; i < MAX_PARITY; i++) begin
         row_sum[i]    = row_sum[i] ^ gf_times(sym, row_weight[i]);
         row_weight[i] = gf_times(row_weight[i], row_base[i]);
      end
      symbols_taken++;
      if (symbols_taken >= stripe_length()) begin
         rows = parity_rows();
         for (int r = 0; r < rows; r++) begin
            beat.symbol = row_sum[r];
            beat.row    = ROW_W'(r);
            beat.last   = (r + 1 == rows);
            pending_parity.push_back(beat);
         end
         for (int i = 0; i < MAX_PARITY; i++) begin
            row_sum[i]    = '0;
            row_weight[i] = SYM_W'(1);
         end
         symbols_taken = 0;
      end
   endtask

   task automatic send_symbol(input logic [SYM_W-1:0] sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_symbol <= sym;
      do @(posedge clock); while (req_stall);
      absorb_symbol(sym);
      symbols_sent++;
   endtask

   function automatic logic [SYM_W-1:0] pick_symbol();
      case ($urandom_range(7))
         0: return 16'hFFFF;
         1: return 16'h0000;
         2: return 16'h8000 >> $urandom_range(15);
         default: return SYM_W'($urandom_range(16'hFFFF));
      endcase
   endfunction

   task automatic send_stripe();
      int len;
      len = stripe_length();
      for (int j = 0; j < len; j++) begin
         send_symbol(pick_symbol());
      end
   endtask

   // hold until every parity beat is out and the block has settled
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_parity.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_DATA_COUNT) begin
         k_setting = value;
      end else if (idx == CSR_TOTAL_COUNT) begin
         total_chunks = value;
      end
      csr_writes++;
   endtask

   task automatic set_geometry(input int k, input int n);
      write_csr(CSR_DATA_COUNT, CFG_W'(k));
      write_csr(CSR_TOTAL_COUNT, CFG_W'(n));
   endtask

   // checker: pop the oldest expectation on each accepted result beat
   always @(posedge clock) begin : parity_monitor
      parity_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_parity.size() == 0) begin
               $error("unexpected parity beat: symbol %h row %0d last %b",
                      rsp_parity_symbol, rsp_parity_row, rsp_last_parity);
               failures++;
            end else begin
               want = pending_parity.pop_front();
               beats_checked++;
               if (rsp_parity_symbol !== want.symbol) begin
                  $error("parity_symbol: expected %h, got %h", want.symbol, rsp_parity_symbol);
                  failures++;
               end
               if (rsp_parity_row !== want.row) begin
                  $error("parity_row: expected %0d, got %0d", want.row, rsp_parity_row);
                  failures++;
               end
               if (rsp_last_parity !== want.last) begin
                  $error("last_parity: expected %b, got %b", want.last, rsp_last_parity);
                  failures++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // reset geometry K=3, N=5: two parity rows, two stripes with all-zero, all-one and other data
   task automatic test_reset_geometry();
      send_symbol(16'h0000);
      send_symbol(16'hFFFF);
      send_symbol(16'h8000);
      send_symbol(16'h0001);
      send_symbol(16'h7FFF);
      send_symbol(16'hAAAA);
   endtask

   task automatic test_count_clipping();
      // K of zero acts as one, N below K gives one row
      set_geometry(0, 0);
      send_symbol(16'h5555);
      // parity count above the row limit
      set_geometry(1, 31);
      send_symbol(16'hFFFF);
      // K above MAX_DATA clips to the full stripe
      set_geometry(31, 2);
   endtask

   task automatic test_unmapped_index();
      write_csr(CSR_UNMAPPED_A, CFG_W'(1));
      write_csr(CSR_UNMAPPED_B, CFG_W'(1));
      send_stripe();
   endtask

   task automatic test_random_stripes(input int idle_pct, input int stall_pct,
                                      input int first_k, input int first_n);
      int start;
      int k;
      int n;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start          = symbols_sent;
      set_geometry(first_k, first_n);
      while (symbols_sent - start < PHASE_SYMBOLS) begin
         repeat ($urandom_range(1, 4)) send_stripe();
         case ($urandom_range(9))
            0, 1:    k = $urandom_range(31);
            2, 3:    k = $urandom_range(7, 16);
            default: k = $urandom_range(1, 6);
         endcase
         if ($urandom_range(1)) begin
            n = $urandom_range(31);
         end else begin
            n = (k > 16 ? 16 : k) + $urandom_range(1, 8);
            if (n > 31) begin
               n = 31;
            end
         end
         set_geometry(k, n);
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_symbol = '0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      failures        = 0;
      symbols_sent    = 0;
      beats_checked   = 0;
      csr_writes      = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      clear_encoder_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_count_clipping();
      test_unmapped_index();
      test_random_stripes(0, 0, 16, 24);
      test_random_stripes(60, 0, 1, 9);
      test_random_stripes(0, 60, 2, 2);
      test_random_stripes(10, 10, 16, 31);

      wait_quiet();
      $display("Sent %0d data symbols, checked %0d parity beats, made %0d register writes.",
               symbols_sent, beats_checked, csr_writes);
      $display("Stripe sizes 1..16, parity rows 1..8, with and without sender gaps and stalls.");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout waiting for the encoder");
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: rs_vandermonde_parity_encoder_gf16.f
rtl/rsvpe_pkg.sv
rtl/rsvpe_dp.sv
rtl/rsvpe_ctrl.sv
rtl/rs_vandermonde_parity_encoder_gf16.sv
verif/rs_vandermonde_parity_encoder_gf16_test.sv
